[src/sscl_pkg.sv]
// Shared types and constants for the shadow state cache with dirty list.
// Used by the channel interfaces, the controller, the datapath and the top level.
package sscl_pkg;

   localparam int NUM_STATES_DEF = 32;
   localparam int IDX_W = 5;
   localparam int VAL_W = 32;

   localparam logic KIND_SET   = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_req;    // capture set request, read pending entry
      logic set_write;   // write pending entry
      logic mark_new;    // mark dirty, append to list, bump count
      logic list_rd;     // read list entry at walk pointer
      logic entry_rd;    // read pending and shadow of listed entry, clear its mark
      logic emit_write;  // load device write into result register, update shadow
      logic emit_term;   // load terminator, empty the list
      logic ptr_inc;     // advance walk pointer
   } sscl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_flush;
      logic idx_ok;
      logic differ_set;
      logic was_dirty;
      logic room;
      logic walk_done;
      logic differ_walk;
      logic rsp_free;
   } sscl_sts_type;

endpackage

[src/sscl_if.sv]
// Request and response channel interfaces (valid/ready handshake).
// Depends on sscl_pkg for field widths.
interface sscl_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [sscl_pkg::IDX_W-1:0] state_index;
   logic [sscl_pkg::VAL_W-1:0] value;

   modport source (output valid, output kind, output state_index, output value, input ready);
   modport sink   (input valid, input kind, input state_index, input value, output ready);
endinterface

interface sscl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      write_valid;
   logic [sscl_pkg::IDX_W-1:0] write_index;
   logic [sscl_pkg::VAL_W-1:0] write_value;
   logic                      last;

   modport source (output valid, output write_valid, output write_index, output write_value,
                   output last, input ready);
   modport sink   (input valid, input write_valid, input write_index, input write_value,
                   input last, output ready);
endinterface

[src/sscl_ctrl.sv]
// Controller state machine: sequences set updates and the flush walk.
// Depends on sscl_pkg for the command and status structs.
module sscl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sscl_pkg::sscl_sts_type sts,
   output sscl_pkg::sscl_cmd_type cmd
);
   import sscl_pkg::*;

   typedef enum logic [5:0] {
      IDLE    = 6'b000001,
      SET_CMP = 6'b000010,
      WK_LIST = 6'b000100,
      WK_READ = 6'b001000,
      WK_CMP  = 6'b010000,
      WK_TERM = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (sts.is_flush) begin
                  state_in = WK_LIST;
               end else if (sts.idx_ok) begin
                  cmd.load_req = 1'b1;
                  state_in     = SET_CMP;
               end
            end
         end
         SET_CMP: begin
            if (sts.differ_set) begin
               cmd.set_write = 1'b1;
               cmd.mark_new  = !sts.was_dirty && sts.room;
            end
            state_in = IDLE;
         end
         WK_LIST: begin
            if (sts.walk_done) begin
               state_in = WK_TERM;
            end else begin
               cmd.list_rd = 1'b1;
               state_in    = WK_READ;
            end
         end
         WK_READ: begin
            cmd.entry_rd = 1'b1;
            state_in     = WK_CMP;
         end
         WK_CMP: begin
            // hold while a device write waits on a full result register
            if (!sts.differ_walk) begin
               cmd.ptr_inc = 1'b1;
               state_in    = WK_LIST;
            end else if (sts.rsp_free) begin
               cmd.emit_write = 1'b1;
               cmd.ptr_inc    = 1'b1;
               state_in       = WK_LIST;
            end
         end
         WK_TERM: begin
            if (sts.rsp_free) begin
               cmd.emit_term = 1'b1;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/sscl_dp.sv]
// Datapath: pending, shadow and dirty-list memories, count, walk pointer, result register.
// Depends on sscl_pkg and the response interface in sscl_if.
module sscl_dp #(
   parameter int NUM_STATES = sscl_pkg::NUM_STATES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_kind,
   input  logic [sscl_pkg::IDX_W-1:0] req_state_index,
   input  logic [sscl_pkg::VAL_W-1:0] req_value,
   input  sscl_pkg::sscl_cmd_type      cmd,
   output sscl_pkg::sscl_sts_type      sts,
   sscl_rsp_if.source                 rsp
);
   import sscl_pkg::*;

   localparam int ADDR_W = $clog2(NUM_STATES);
   localparam int CNT_W  = $clog2(NUM_STATES + 1);

   logic [VAL_W-1:0]  pend_mem [NUM_STATES];
   logic [VAL_W-1:0]  shad_mem [NUM_STATES];
   logic [ADDR_W-1:0] list_mem [NUM_STATES];

   logic [NUM_STATES-1:0] pend_vld_ff;
   logic [NUM_STATES-1:0] shad_vld_ff;
   logic [NUM_STATES-1:0] dirty_ff;

   logic [ADDR_W-1:0] idx_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [ADDR_W-1:0] list_rd_ff;
   logic [VAL_W-1:0]  pend_rd_ff;
   logic              pend_rd_vld_ff;
   logic [VAL_W-1:0]  shad_rd_ff;
   logic              shad_rd_vld_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;

   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_wv_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [VAL_W-1:0]  rsp_val_ff;
   logic              rsp_last_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic [VAL_W-1:0]  pend_eff;
   logic [VAL_W-1:0]  shad_eff;

   // entries never written read as zero
   assign pend_eff = pend_rd_vld_ff ? pend_rd_ff : '0;
   assign shad_eff = shad_rd_vld_ff ? shad_rd_ff : '0;
   assign rd_addr  = cmd.load_req ? ADDR_W'(req_state_index) : list_rd_ff;

   assign sts.is_flush    = (req_kind == KIND_FLUSH);
   assign sts.idx_ok      = (9'(req_state_index) < 9'(NUM_STATES));
   assign sts.differ_set  = (pend_eff != val_ff);
   assign sts.was_dirty   = dirty_ff[idx_ff];
   assign sts.room        = (count_ff < CNT_W'(NUM_STATES));
   assign sts.walk_done   = (ptr_ff == count_ff);
   assign sts.differ_walk = (pend_eff != shad_eff);
   assign sts.rsp_free    = !rsp_vld_ff || rsp.ready;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.set_write) begin
         pend_mem[idx_ff] <= val_ff;
      end
      if (cmd.load_req || cmd.entry_rd) begin
         pend_rd_ff     <= pend_mem[rd_addr];
         pend_rd_vld_ff <= pend_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_write) begin
         shad_mem[list_rd_ff] <= pend_eff;
      end
      if (cmd.entry_rd) begin
         shad_rd_ff     <= shad_mem[rd_addr];
         shad_rd_vld_ff <= shad_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_new) begin
         list_mem[count_ff[ADDR_W-1:0]] <= idx_ff;
      end
      if (cmd.list_rd) begin
         list_rd_ff <= list_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   // captured set request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         idx_ff <= ADDR_W'(req_state_index);
         val_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= '0;
         shad_vld_ff <= '0;
         dirty_ff    <= '0;
      end else begin
         if (cmd.set_write) begin
            pend_vld_ff[idx_ff] <= 1'b1;
         end
         if (cmd.emit_write) begin
            shad_vld_ff[list_rd_ff] <= 1'b1;
         end
         if (cmd.mark_new) begin
            dirty_ff[idx_ff] <= 1'b1;
         end
         if (cmd.entry_rd) begin
            dirty_ff[list_rd_ff] <= 1'b0;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.mark_new) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.emit_term) begin
         count_in = '0;
         ptr_in   = '0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      if (cmd.emit_write || cmd.emit_term) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ptr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_write) begin
         rsp_wv_ff   <= 1'b1;
         rsp_idx_ff  <= IDX_W'(list_rd_ff);
         rsp_val_ff  <= pend_eff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit_term) begin
         rsp_wv_ff   <= 1'b0;
         rsp_idx_ff  <= '0;
         rsp_val_ff  <= '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.write_valid = rsp_wv_ff;
   assign rsp.write_index = rsp_idx_ff;
   assign rsp.write_value = rsp_val_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

[src/shadow_state_dirty_list_cache_top.sv]
// Top level of the shadow state cache with dirty list.
// Depends on sscl_pkg, sscl_if, sscl_ctrl and sscl_dp.
//
// Usage:
//   req channel: kind 0 sets state_index to value; kind 1 flushes the dirty list.
//   rsp channel: one device write (write_valid 1) per flushed entry whose pending
//   value differs from the device shadow, in first-dirtied order, then a
//   terminator with last 1 and all other fields zero.
//   A set request is a pending table read, then a compare and update, and
//   produces no response. An index at or beyond NUM_STATES is dropped.
//   A flush costs each listed entry a list read, a pending/shadow read and a
//   compare, since the tables have one read port each. Requests are taken only
//   between operations.
//   A single result register sits on rsp; a stalled receiver holds the walk
//   at the next write or the terminator, and a new request may be taken
//   while the last result still waits.
//   Reset empties all tables at once through per-entry valid bits and the list count; no sweep.
module shadow_state_dirty_list_cache_top #(
   parameter int NUM_STATES = sscl_pkg::NUM_STATES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sscl_req_if.sink   req,
   sscl_rsp_if.source rsp
);
   import sscl_pkg::*;

   sscl_cmd_type cmd;
   sscl_sts_type sts;
   logic         ready;

   assign req.ready = ready;

   sscl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sscl_dp #(
      .NUM_STATES (NUM_STATES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req.kind),
      .req_state_index (req.state_index),
      .req_value       (req.value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp             (rsp)
   );

`ifndef SYNTHESIS
   a_write_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.write_valid != rsp.last))
      else $error("write result and last mark disagree");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last) |->
         (rsp.write_index == '0 && rsp.write_value == '0))
      else $error("terminator carries nonzero fields");

   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.kind == KIND_FLUSH) |=> !req.ready)
      else $error("request taken during flush walk");
`endif

endmodule
